// ===== rtl/skws_pkg.sv =====
// ----------------------------------------------------------------------------
// skws_pkg: shared types and constants for the switch/key point selector
// Beat layouts, config register map, mode encodings and thresholds.
// ----------------------------------------------------------------------------
package skws_pkg;

    // Config register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINT_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS      = 2'd1;
    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] MAX_POINT_RESET  = 8'd255;
    localparam logic [9:0] HOLD_TICKS_RESET = 10'd125;

    // Stick thresholds
    localparam logic signed [7:0] POS_HIGH = 8'sd50;
    localparam logic signed [7:0] POS_LOW  = -8'sd50;

    // Voice cue codes
    localparam logic [1:0] ANN_NONE   = 2'd0;
    localparam logic [1:0] ANN_NEXT   = 2'd1;
    localparam logic [1:0] ANN_STORED = 2'd2;

    typedef enum logic [3:0] {
        SW_NONE = 4'b0001,
        SW_MID  = 4'b0010,
        SW_UP   = 4'b0100,
        SW_DOWN = 4'b1000
    } sw_mode_t;

    typedef enum logic [2:0] {
        KEY_PRESSED  = 3'b001,
        KEY_IDLE     = 3'b010,
        KEY_RELEASED = 3'b100
    } key_mode_t;

    typedef struct packed {
        logic signed [7:0] switch_value;
        logic signed [7:0] key_value;
    } tick_t;

    typedef struct packed {
        logic [7:0] load_index;
        logic [7:0] store_index;
        logic [1:0] announce;
    } result_t;

    typedef struct packed {
        logic [7:0] max_point_index;
        logic [9:0] hold_ticks;
    } cfg_t;

endpackage

// ===== rtl/skws_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// skws_cfg_regs: configuration register file
// Write-only registers; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module skws_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [skws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skws_pkg::CFG_DATA_W-1:0]  cfg_data,
    output skws_pkg::cfg_t                   cfg
);

    skws_pkg::cfg_t cfg_reg;
    skws_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                skws_pkg::CFG_MAX_POINT_INDEX: cfg_next.max_point_index = cfg_data[7:0];
                skws_pkg::CFG_HOLD_TICKS:      cfg_next.hold_ticks      = cfg_data[9:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_point_index <= skws_pkg::MAX_POINT_RESET;
            cfg_reg.hold_ticks      <= skws_pkg::HOLD_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/skws_step.sv =====
// ----------------------------------------------------------------------------
// skws_step: per-tick selector state and next-state logic
// Holds switch/key modes, counters and hold timer; builds one result per tick.
// ----------------------------------------------------------------------------
module skws_step (
    input  logic                clk,
    input  logic                rst_n,
    input  skws_pkg::cfg_t      cfg,
    input  logic                take,
    input  skws_pkg::tick_t     beat,
    output skws_pkg::result_t   result
);

    skws_pkg::sw_mode_t  sw_mode_reg,  sw_mode_next;
    skws_pkg::key_mode_t key_mode_reg, key_mode_next;
    logic [7:0]          load_cnt_reg,  load_cnt_next;
    logic [7:0]          store_cnt_reg, store_cnt_next;
    logic [9:0]          timer_reg,     timer_next;

    logic       sw_up, sw_down, key_high, key_low;
    logic       entry, stepped;
    logic [9:0] timer_dec;
    logic [7:0] cnt_base, cnt0, cnt1, idx;

    always_comb
    begin
        sw_up    = beat.switch_value > skws_pkg::POS_HIGH;
        sw_down  = beat.switch_value < skws_pkg::POS_LOW;
        key_high = beat.key_value > skws_pkg::POS_HIGH;
        key_low  = beat.key_value < skws_pkg::POS_LOW;

        // timer counts down before the key is looked at
        timer_dec = (timer_reg != 10'd0) ? timer_reg - 10'd1 : 10'd0;

        sw_mode_next   = sw_mode_reg;
        key_mode_next  = key_mode_reg;
        load_cnt_next  = load_cnt_reg;
        store_cnt_next = store_cnt_reg;
        timer_next     = timer_dec;

        cnt_base = sw_up ? load_cnt_reg : store_cnt_reg;
        entry    = sw_up   ? (sw_mode_reg == skws_pkg::SW_MID || sw_mode_reg == skws_pkg::SW_DOWN)
                 : sw_down ? (sw_mode_reg == skws_pkg::SW_MID || sw_mode_reg == skws_pkg::SW_UP)
                 : 1'b0;
        cnt0     = entry ? 8'd1 : cnt_base;
        cnt1     = cnt0;
        stepped  = 1'b0;

        if (key_high)
        begin
            key_mode_next = skws_pkg::KEY_RELEASED;
            if (timer_dec == 10'd0)
            begin
                cnt1          = 8'd0;
                key_mode_next = skws_pkg::KEY_IDLE;
            end
        end
        else if (key_low)
        begin
            timer_next = cfg.hold_ticks;
            if (key_mode_reg == skws_pkg::KEY_RELEASED && cnt0 < cfg.max_point_index)
            begin
                cnt1    = cnt0 + 8'd1;
                stepped = 1'b1;
            end
            key_mode_next = skws_pkg::KEY_PRESSED;
        end

        // key step beats a switch entry for the index field
        idx = stepped ? cnt1 : (entry ? 8'd1 : 8'd0);

        result.load_index  = 8'd0;
        result.store_index = 8'd0;
        result.announce    = skws_pkg::ANN_NONE;

        if (sw_up)
        begin
            if (entry)
                sw_mode_next = skws_pkg::SW_UP;
            load_cnt_next      = cnt1;
            result.load_index  = idx;
            if (entry || stepped)
                result.announce = skws_pkg::ANN_NEXT;
        end
        else if (sw_down)
        begin
            if (entry)
                sw_mode_next = skws_pkg::SW_DOWN;
            store_cnt_next     = cnt1;
            result.store_index = idx;
            if (entry || stepped)
                result.announce = skws_pkg::ANN_STORED;
        end
        else
        begin
            // middle: key ignored, mode set to middle, only the timer moves
            sw_mode_next  = skws_pkg::SW_MID;
            key_mode_next = key_mode_reg;
            timer_next    = timer_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_mode_reg   <= skws_pkg::SW_NONE;
            key_mode_reg  <= skws_pkg::KEY_IDLE;
            load_cnt_reg  <= 8'd0;
            store_cnt_reg <= 8'd0;
            timer_reg     <= 10'd0;
        end
        else if (take)
        begin
            sw_mode_reg   <= sw_mode_next;
            key_mode_reg  <= key_mode_next;
            load_cnt_reg  <= load_cnt_next;
            store_cnt_reg <= store_cnt_next;
            timer_reg     <= timer_next;
        end
    end

endmodule

// ===== rtl/switch_key_waypoint_selector_core.sv =====
// ----------------------------------------------------------------------------
// switch_key_waypoint_selector_core: switch/key driven point load/store select
// Turns one receiver tick (mode switch + push key) into load/store requests.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                  beat
//  -------   ---   -------------------------  ------------------------------
//  tick      in    tick_valid / tick_stall    switch_value, key_value
//  result    out   result_valid / result_stall load_index, store_index, announce
//  cfg       in    cfg_we (no wait)           cfg_index, cfg_data
//
//  One beat per cycle sustained while result_stall is low; each beat passes
//  the tick register, then skws_step once, then the result register.
//  Reset clears modes, counters, timer and both valid flags; config returns
//  to max_point_index 255, hold_ticks 125.
//  A stalled result holds. The tick register takes a beat whenever it is
//  empty or its beat moves on; once both registers are full, tick_stall
//  follows result_stall in the same cycle, so two beats sit in the block
//  under a long stall.
//
module switch_key_waypoint_selector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  skws_pkg::tick_t                  tick,
    output logic                             result_valid,
    input  logic                             result_stall,
    output skws_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [skws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skws_pkg::CFG_DATA_W-1:0]  cfg_data
);

    skws_pkg::cfg_t    cfg;
    skws_pkg::result_t step_result;

    // tick register
    logic              tick_vld_reg, tick_vld_next;
    skws_pkg::tick_t   tick_reg;
    // result register
    logic              res_vld_reg, res_vld_next;
    skws_pkg::result_t res_reg;

    logic advance;      // tick register moves into result register
    logic tick_take;    // new beat accepted on tick channel

    skws_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state only commits when the held beat actually moves on
    skws_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .take   (advance),
        .beat   (tick_reg),
        .result (step_result)
    );

    always_comb
    begin
        advance       = tick_vld_reg && (!res_vld_reg || !result_stall);
        tick_stall    = tick_vld_reg && !advance;
        tick_take     = tick_valid && !tick_stall;
        tick_vld_next = tick_take || (tick_vld_reg && !advance);
        res_vld_next  = advance || (res_vld_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            tick_vld_reg <= tick_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
            tick_reg <= tick;
        if (advance)
            res_reg <= step_result;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/skws_checker.sv =====
// ----------------------------------------------------------------------------
// skws_checker: port-level assertions for the selector core
// Watches the result channel only; attached by bind.
// ----------------------------------------------------------------------------
module skws_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_valid,
    input  logic               result_stall,
    input  skws_pkg::result_t  result
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed under stall");

    // never both a load and a store in one tick
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.load_index == 8'd0 || result.store_index == 8'd0))
        else $error("load and store requested together");

    // a load request always carries the next-point cue
    a_load_cue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.load_index != 8'd0 |-> result.announce == skws_pkg::ANN_NEXT)
        else $error("load request without next-point cue");

    // a store request always carries the stored cue
    a_store_cue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.store_index != 8'd0
            |-> result.announce == skws_pkg::ANN_STORED)
        else $error("store request without stored cue");

    // no cue without a request
    a_cue_req: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.announce != skws_pkg::ANN_NONE
            |-> (result.load_index != 8'd0 || result.store_index != 8'd0))
        else $error("cue without request");

endmodule

bind switch_key_waypoint_selector_core skws_checker u_skws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
